// File: hw/rtl/dsf_pkg.sv
package dsf_pkg;

   localparam int BLOCK_BYTES_DEF = 4096;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [31:0] ID_DSD = 32'h2044_5344;
   localparam logic [31:0] ID_FMT = 32'h2074_6d66;
   localparam logic [31:0] ID_DATA = 32'h6174_6164;
   localparam logic [31:0] DSD_RATE_HZ = 32'd2822400;

   typedef enum logic [2:0] {
      ST_PAIR        = 3'd0,
      ST_BAD_HEADER  = 3'd1,
      ST_BAD_FMT     = 3'd2,
      ST_UNSUPPORTED = 3'd3,
      ST_BAD_DATA_ID = 3'd4,
      ST_ACCEPTED    = 3'd5
   } status_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_file;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  left_byte;
      logic [7:0]  right_byte;
      logic [47:0] data_bytes;
      logic        last;
   } rsp_type;

   // Work handed from the parser to the output side.
   // pair beats leave the left byte to the registered store read
   typedef struct packed {
      logic       is_pair;
      logic       reverse;
      rsp_type    rsp;
   } job_type;

   function automatic logic [7:0] rev8(input logic [7:0] v);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[7-i] = v[i];
      return r;
   endfunction

endpackage

// File: hw/rtl/dsf_ram.sv
module dsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: hw/rtl/dsf_front.sv
module dsf_front
   import dsf_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  req_type                        in_req,
   output logic                           job_valid,
   output job_type                        job,
   output logic                           st_wr_en,
   output logic [$clog2(BLOCK_BYTES)-1:0] st_wr_addr,
   output logic [7:0]                     st_wr_data,
   output logic                           st_rd_en,
   output logic [$clog2(BLOCK_BYTES)-1:0] st_rd_addr
);
   localparam int AW = $clog2(BLOCK_BYTES);
   localparam int HW = $clog2(BLOCK_BYTES + 1);
   localparam int GW = HW + 1;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_DATA   = 4'b0010,
      PH_DONE   = 4'b0100,
      PH_FAIL   = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [6:0]  pos_ff, pos_in;
   logic [63:0] acc_ff, acc_in;
   logic        rev_ff, rev_in;
   logic [47:0] rem_ff, rem_in;
   logic [HW-1:0] half_ff, half_in;
   logic [GW-1:0] gpos_ff, gpos_in;

   phase_type   ph;
   logic [6:0]  pos;
   logic [63:0] acc;
   logic [63:0] acc_new;
   logic        rev;
   logic [47:0] rem;
   logic [GW-1:0] gpos;
   logic [HW-1:0] half;
   logic [2:0]  k;
   logic        in_field, field_end;
   logic [2:0]  st;
   logic [63:0] size;
   logic [47:0] hrem;

   always_comb begin
      // restart on start of file
      ph   = phase_ff;
      pos  = pos_ff;
      acc  = acc_ff;
      rev  = rev_ff;
      rem  = rem_ff;
      gpos = gpos_ff;
      half = half_ff;
      if (in_req.start_of_file) begin
         ph = PH_HEADER; pos = '0; acc = '0; rev = 1'b0;
         rem = '0; gpos = '0; half = '0;
      end
      phase_in = ph; pos_in = pos; acc_in = acc; rev_in = rev;
      rem_in = rem; gpos_in = gpos; half_in = half;
      job_valid = 1'b0;
      job = '0;
      st_wr_en = 1'b0;
      st_wr_addr = gpos[AW-1:0];
      st_wr_data = in_req.data_byte;
      st_rd_en = 1'b0;
      st_rd_addr = '0;
      st = ST_PAIR;
      size = acc_new - 64'd12;
      hrem = rem >> 1;

      // locate the field byte
      in_field = 1'b1;
      field_end = 1'b0;
      k = pos[2:0];
      if (pos < 7'd4) begin k = pos[2:0]; field_end = (pos == 7'd3); end
      else if (pos < 7'd12) begin k = 3'(pos - 7'd4); field_end = (pos == 7'd11); end
      else if (pos < 7'd28) in_field = 1'b0;
      else if (pos < 7'd32) begin k = 3'(pos - 7'd28); field_end = (pos == 7'd31); end
      else if (pos < 7'd40) begin k = 3'(pos - 7'd32); field_end = (pos == 7'd39); end
      else if (pos < 7'd64) begin k = {1'b0, pos[1:0]}; field_end = (pos[1:0] == 2'd3); end
      else if (pos < 7'd72) in_field = 1'b0;
      else if (pos < 7'd76) begin k = {1'b0, pos[1:0]}; field_end = (pos[1:0] == 2'd3); end
      else if (pos < 7'd80) in_field = 1'b0;
      else if (pos < 7'd84) begin k = {1'b0, pos[1:0]}; field_end = (pos[1:0] == 2'd3); end
      else if (pos < 7'd92) begin k = 3'(pos - 7'd84); field_end = (pos == 7'd91); end
      else in_field = 1'b0;

      acc_new = ((k == 3'd0) ? 64'd0 : acc) | (64'(in_req.data_byte) << {k, 3'b000});

      unique case (ph)
         PH_HEADER: begin
            pos_in = pos + 7'd1;
            if (in_field) begin
               acc_in = acc_new;
               if (field_end) begin
                  unique case (pos)
                     7'd3:  st = (acc_new[31:0] == ID_DSD) ? ST_PAIR : ST_BAD_HEADER;
                     7'd11: st = (acc_new == 64'd28) ? ST_PAIR : ST_BAD_HEADER;
                     7'd31: st = (acc_new[31:0] == ID_FMT) ? ST_PAIR : ST_BAD_FMT;
                     7'd39: st = (acc_new == 64'd52) ? ST_PAIR : ST_BAD_FMT;
                     7'd43: st = (acc_new[31:0] == 32'd1) ? ST_PAIR : ST_UNSUPPORTED;
                     7'd47: st = (acc_new[31:0] == 32'd0) ? ST_PAIR : ST_UNSUPPORTED;
                     7'd51, 7'd55:
                        st = (acc_new[31:0] == 32'd2) ? ST_PAIR : ST_UNSUPPORTED;
                     7'd59: st = (acc_new[31:0] == DSD_RATE_HZ) ? ST_PAIR : ST_UNSUPPORTED;
                     7'd63: rev_in = (acc_new[31:0] == 32'd1);
                     7'd75: st = (acc_new[31:0] == 32'(BLOCK_BYTES)) ? ST_PAIR
                                                                   : ST_UNSUPPORTED;
                     7'd83: st = (acc_new[31:0] == ID_DATA) ? ST_PAIR : ST_BAD_DATA_ID;
                     default: begin
                        if (size[63:48] != 16'd0) st = ST_UNSUPPORTED;
                        else begin
                           st = ST_ACCEPTED;
                           rem_in = size[47:0];
                        end
                     end
                  endcase
               end
            end
            if (st != ST_PAIR) begin
               job_valid = 1'b1;
               job.rsp.status = st;
               if (st == ST_ACCEPTED) begin
                  job.rsp.data_bytes = size[47:0];
                  phase_in = (size[47:0] != 48'd0) ? PH_DATA : PH_DONE;
               end else begin
                  phase_in = PH_FAIL;
               end
            end
         end
         PH_DATA: begin
            if (rem == 48'd0) phase_in = PH_DONE;
            else begin
               if (gpos == '0)
                  half = (hrem < 48'(BLOCK_BYTES)) ? HW'(hrem) : HW'(BLOCK_BYTES);
               half_in = half;
               if (half == '0) begin
                  rem_in = '0;
                  phase_in = PH_DONE;
               end else begin
                  rem_in = rem - 48'd1;
                  if (gpos < GW'(half)) begin
                     st_wr_en = 1'b1;
                     gpos_in = gpos + GW'(1);
                  end else begin
                     st_rd_en = 1'b1;
                     st_rd_addr = AW'(gpos - GW'(half));
                     gpos_in = (gpos + GW'(1) >= {half, 1'b0}) ? '0 : gpos + GW'(1);
                     job_valid = 1'b1;
                     job.is_pair = 1'b1;
                     job.reverse = rev;
                     job.rsp.status = ST_PAIR;
                     job.rsp.right_byte = in_req.data_byte;
                     job.rsp.last = (rem_in < 48'd2);
                     if (rem_in == 48'd0) phase_in = PH_DONE;
                  end
               end
            end
         end
         PH_DONE, PH_FAIL: ;
         default: ;
      endcase

      if (!in_valid) begin
         phase_in = phase_ff; pos_in = pos_ff; acc_in = acc_ff; rev_in = rev_ff;
         rem_in = rem_ff; gpos_in = gpos_ff; half_in = half_ff;
         job_valid = 1'b0; st_wr_en = 1'b0; st_rd_en = 1'b0;
      end
   end

   // advance parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER; pos_ff <= '0; acc_ff <= '0; rev_ff <= 1'b0;
         rem_ff <= '0; gpos_ff <= '0; half_ff <= '0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; acc_ff <= acc_in; rev_ff <= rev_in;
         rem_ff <= rem_in; gpos_ff <= gpos_in; half_ff <= half_in;
      end
   end
endmodule

// File: hw/rtl/dsf_back.sv
module dsf_back
   import dsf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   input  logic [7:0] st_rd_data,
   output logic       slots_low,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output rsp_type    rsp_data
);
   localparam int QW = $clog2(QUEUE_DEPTH);

   // the staging register waits for the store read, then the job joins the queue
   logic    stg_valid_ff;
   job_type stg_ff;
   rsp_type stg_rsp;
   rsp_type q_ff [QUEUE_DEPTH];
   logic [QW-1:0] wp_ff, rp_ff;
   logic [QW:0]   cnt_ff, cnt_in;
   logic pop;

   always_comb begin
      stg_rsp = stg_ff.rsp;
      if (stg_ff.is_pair)
         stg_rsp.left_byte = stg_ff.reverse ? rev8(st_rd_data) : st_rd_data;
      if (stg_ff.is_pair && stg_ff.reverse)
         stg_rsp.right_byte = rev8(stg_ff.rsp.right_byte);
   end

   assign pop = rsp_pop && !rsp_empty;
   assign rsp_empty = (cnt_ff == '0);
   assign rsp_data = q_ff[rp_ff];
   assign cnt_in = cnt_ff + (QW+1)'(stg_valid_ff) - (QW+1)'(pop);
   // leave room for the beat in the stage
   assign slots_low = (cnt_ff + (QW+1)'(stg_valid_ff)) >= (QW+1)'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      stg_ff <= job;
      if (stg_valid_ff) q_ff[wp_ff] <= stg_rsp;
      if (reset) begin
         stg_valid_ff <= 1'b0; wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         stg_valid_ff <= job_valid;
         if (stg_valid_ff) wp_ff <= wp_ff + QW'(1);
         if (pop) rp_ff <= rp_ff + QW'(1);
         cnt_ff <= cnt_in;
      end
   end
endmodule

// File: hw/rtl/dsf_stream_parse_deinterleave.sv
// DSF stream parser and stereo deinterleaver.
// Input queue port: one file byte per beat on req_data (push/full). A beat
// with start_of_file set restarts the parse at header byte 0.
// Result queue port: rsp_data holds the oldest result while empty is low;
// pop takes it. Results are header errors, the accepted status with the
// audio data size, and left/right sample pairs (last marks the final pair).
// Throughput: one byte per cycle while full is low, set by the combinational
// front parser and at most one store access per byte (left bytes written,
// right bytes read). A result passes the staging register, which waits for
// the registered store read, and is then written into the result queue.
// Reset clears parse state and the result queue; store contents are left.
// When the receiver stalls, the staging register and the four-entry result
// queue fill and full rises; no beat is lost. Bytes that produce no result
// still pass at full rate while the queue has room.
module dsf_stream_parse_deinterleave
   import dsf_pkg::*;
#(
   parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);
   localparam int AW = $clog2(BLOCK_BYTES);

   logic    accept, job_valid, st_wr_en, st_rd_en, slots_low;
   job_type job;
   logic [AW-1:0] st_wr_addr, st_rd_addr;
   logic [7:0] st_wr_data, st_rd_data;

   assign full = slots_low;
   assign accept = push && !full;

   dsf_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .clock, .reset, .in_valid(accept), .in_req(req_data),
      .job_valid, .job, .st_wr_en, .st_wr_addr, .st_wr_data,
      .st_rd_en, .st_rd_addr
   );

   dsf_ram #(.WIDTH(8), .DEPTH(BLOCK_BYTES)) u_store (
      .clock, .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_data),
      .rd_en(st_rd_en), .rd_addr(st_rd_addr), .rd_data(st_rd_data)
   );

   dsf_back u_back (
      .clock, .reset, .job_valid, .job, .st_rd_data, .slots_low,
      .rsp_empty(empty), .rsp_pop(pop), .rsp_data
   );

   // a job only leaves the parser for an accepted beat
   a_job_on_accept: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> accept) else $error("job without accepted beat");

   // store never written and read in the same cycle
   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(st_wr_en && st_rd_en)) else $error("store access clash");

   // last only marks a sample pair
   a_pair_status: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.last) |-> (rsp_data.status == ST_PAIR))
      else $error("last on non-pair result");
endmodule

// File: sim/dsf_stream_parse_deinterleave_tb.sv
module dsf_stream_parse_deinterleave_tb;
   import dsf_pkg::*;

   localparam int BLK = BLOCK_BYTES_DEF;
   localparam int STALL_LIMIT = 5000;

   typedef enum int {
      FK_HDR_ID, FK_HDR_SIZE, FK_FMT_ID, FK_FMT_SIZE, FK_VERSION, FK_FORMAT,
      FK_CHTYPE, FK_CHNUM, FK_FREQ, FK_BITS, FK_BLOCK, FK_DATA_ID, FK_DATA_SIZE,
      FK_NONE
   } field_kind_type;

   typedef enum logic [1:0] {P_HEADER, P_DATA, P_DONE, P_FAIL} parse_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full;
   logic    empty;
   req_type req_data = '0;
   rsp_type rsp_data;

   dsf_stream_parse_deinterleave u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   // file bytes waiting to be sent, and results the parser should produce
   req_type      pending_bytes[$];
   rsp_type      expected_results[$];
   logic [7:0]   file_buf[$];

   // predicted parser state
   parse_phase_type pr_phase;
   int           pr_hpos;
   logic [63:0]  pr_acc;
   logic         pr_reverse;
   logic [47:0]  pr_remaining;
   int           pr_half;
   int           pr_gpos;
   logic [7:0]   pr_store [BLK];

   int fail_count = 0;
   int result_count = 0;
   int idle_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // byte range of each header field
   function automatic void field_span(input int idx, output int s, output int l);
      case (field_kind_type'(idx))
         FK_HDR_ID:    begin s = 0;  l = 4; end
         FK_HDR_SIZE:  begin s = 4;  l = 8; end
         FK_FMT_ID:    begin s = 28; l = 4; end
         FK_FMT_SIZE:  begin s = 32; l = 8; end
         FK_VERSION:   begin s = 40; l = 4; end
         FK_FORMAT:    begin s = 44; l = 4; end
         FK_CHTYPE:    begin s = 48; l = 4; end
         FK_CHNUM:     begin s = 52; l = 4; end
         FK_FREQ:      begin s = 56; l = 4; end
         FK_BITS:      begin s = 60; l = 4; end
         FK_BLOCK:     begin s = 72; l = 4; end
         FK_DATA_ID:   begin s = 80; l = 4; end
         default:      begin s = 84; l = 8; end
      endcase
   endfunction

   function automatic void restart_parse();
      pr_phase = P_HEADER;
      pr_hpos = 0;
      pr_acc = '0;
      pr_reverse = 1'b0;
      pr_remaining = '0;
      pr_half = 0;
      pr_gpos = 0;
   endfunction

   // advance the parser model by one byte and queue any result it makes
   function automatic void parse_byte(input req_type r);
      int          s, l, k;
      logic [63:0] size;
      logic        emit;
      status_type  st;
      rsp_type     e;
      logic [7:0]  lb, rb;
      emit = 1'b0;
      st = ST_PAIR;
      e = '0;
      if (r.start_of_file) restart_parse();
      if (pr_phase == P_HEADER) begin
         for (int i = 0; i < FK_NONE; i++) begin
            field_span(i, s, l);
            if (pr_hpos >= s && pr_hpos < s + l) begin
               k = pr_hpos - s;
               if (k == 0) pr_acc = '0;
               pr_acc |= 64'(r.data_byte) << (8 * (k & 7));
               if (k == l - 1) begin
                  emit = 1'b1;
                  case (field_kind_type'(i))
                     FK_HDR_ID:   if (pr_acc == 64'(ID_DSD)) emit = 0; else st = ST_BAD_HEADER;
                     FK_HDR_SIZE: if (pr_acc == 64'd28) emit = 0; else st = ST_BAD_HEADER;
                     FK_FMT_ID:   if (pr_acc == 64'(ID_FMT)) emit = 0; else st = ST_BAD_FMT;
                     FK_FMT_SIZE: if (pr_acc == 64'd52) emit = 0; else st = ST_BAD_FMT;
                     FK_VERSION:  if (pr_acc == 64'd1) emit = 0; else st = ST_UNSUPPORTED;
                     FK_FORMAT:   if (pr_acc == 64'd0) emit = 0; else st = ST_UNSUPPORTED;
                     FK_CHTYPE:   if (pr_acc == 64'd2) emit = 0; else st = ST_UNSUPPORTED;
                     FK_CHNUM:    if (pr_acc == 64'd2) emit = 0; else st = ST_UNSUPPORTED;
                     FK_FREQ:     if (pr_acc == 64'(DSD_RATE_HZ)) emit = 0;
                                  else st = ST_UNSUPPORTED;
                     FK_BITS: begin
                        pr_reverse = (pr_acc == 64'd1);
                        emit = 1'b0;
                     end
                     FK_BLOCK:    if (pr_acc == 64'(BLK)) emit = 0; else st = ST_UNSUPPORTED;
                     FK_DATA_ID:  if (pr_acc == 64'(ID_DATA)) emit = 0; else st = ST_BAD_DATA_ID;
                     default: begin
                        size = pr_acc - 64'd12;
                        if (size[63:48] != 0) st = ST_UNSUPPORTED;
                        else begin
                           pr_remaining = size[47:0];
                           st = ST_ACCEPTED;
                        end
                     end
                  endcase
               end
               break;
            end
         end
         pr_hpos++;
         if (emit) begin
            e.status = st;
            if (st == ST_ACCEPTED) begin
               e.data_bytes = pr_remaining;
               pr_phase = (pr_remaining != 0) ? P_DATA : P_DONE;
            end else begin
               pr_phase = P_FAIL;
            end
            expected_results.push_back(e);
         end
         return;
      end
      if (pr_phase != P_DATA) return;
      if (pr_remaining == 0) begin
         pr_phase = P_DONE;
         return;
      end
      if (pr_gpos == 0) pr_half = (pr_remaining >> 1) < BLK ? int'(pr_remaining >> 1) : BLK;
      // drop the odd leftover byte
      if (pr_half == 0) begin
         pr_remaining = '0;
         pr_phase = P_DONE;
         return;
      end
      pr_remaining--;
      if (pr_gpos < pr_half) begin
         pr_store[pr_gpos % BLK] = r.data_byte;
         pr_gpos++;
         return;
      end
      lb = pr_store[(pr_gpos - pr_half) % BLK];
      rb = r.data_byte;
      pr_gpos++;
      if (pr_gpos >= 2 * pr_half) pr_gpos = 0;
      if (pr_reverse) begin
         lb = {<<{lb}};
         rb = {<<{rb}};
      end
      e.status = ST_PAIR;
      e.left_byte = lb;
      e.right_byte = rb;
      e.last = (pr_remaining < 2);
      if (pr_remaining == 0) pr_phase = P_DONE;
      expected_results.push_back(e);
   endfunction

   function automatic void add_le(input logic [63:0] v, input int n);
      for (int i = 0; i < n; i++) file_buf.push_back(v[8*i +: 8]);
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // build one file; bad_field corrupts that header field, FK_NONE keeps it clean
   function automatic void queue_file(input int bad_field, input logic [31:0] bits,
                                      input logic [63:0] size_field, input int n_data,
                                      input logic with_sof);
      int      s, l;
      req_type r;
      file_buf.delete();
      add_le(ID_DSD, 4);
      add_le(28, 8);
      add_le(rand64(), 8);
      add_le(rand64(), 8);
      add_le(ID_FMT, 4);
      add_le(52, 8);
      add_le(1, 4);
      add_le(0, 4);
      add_le(2, 4);
      add_le(2, 4);
      add_le(DSD_RATE_HZ, 4);
      add_le(bits, 4);
      add_le(rand64(), 8);
      add_le(BLK, 4);
      add_le(rand64(), 4);
      add_le(ID_DATA, 4);
      add_le(size_field, 8);
      if (bad_field != FK_NONE) begin
         field_span(bad_field, s, l);
         file_buf[s + $urandom_range(0, l - 1)] ^= 8'($urandom_range(1, 255));
      end
      repeat (n_data) file_buf.push_back(8'($urandom));
      // cut a corrupted header short after the failing field, unless that is the data size field
      if (bad_field != FK_NONE && bad_field != FK_DATA_SIZE)
         while (file_buf.size() > s + l) void'(file_buf.pop_back());
      foreach (file_buf[i]) begin
         r.data_byte = file_buf[i];
         r.start_of_file = (i == 0) && with_sof;
         pending_bytes.push_back(r);
      end
   endfunction

   function automatic logic [31:0] rand_bits();
      case ($urandom_range(0, 3))
         0, 1:    return 32'd1;
         2:       return 32'd8;
         default: return $urandom;
      endcase
   endfunction

   // stimulus and end of run
   initial begin
      int          n, kind;
      logic [63:0] sz;
      req_type     r;
      // first file starts without a start marker
      queue_file(FK_NONE, 1, 12 + 4, 4, 1'b0);
      queue_file(FK_NONE, 8, 12 + 3, 4, 1'b1);
      queue_file(FK_NONE, 1, 12, 3, 1'b1);
      queue_file(FK_NONE, 1, 12 + 1, 2, 1'b1);
      for (int f = FK_HDR_ID; f < FK_DATA_SIZE; f++)
         if (f != FK_BITS) queue_file(f, 1, 12 + 4, 6, 1'b1);
      queue_file(FK_NONE, 1, 64'd5, 4, 1'b1);
      queue_file(FK_NONE, 8, (64'd1 << 48) + 12, 4, 1'b1);
      queue_file(FK_NONE, 1, (64'd1 << 48) + 11, 4, 1'b1);
      queue_file(FK_NONE, 32'hffff_ffff, 12 + 6, 6, 1'b1);
      // restart in the middle of a file
      queue_file(FK_NONE, 1, 12 + 40, 13, 1'b1);

      // random files, mostly well formed with small data sizes
      while (pending_bytes.size() < 1300) begin
         kind = $urandom_range(0, 99);
         if (kind < 72) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 70);
            sz = 64'(n) + 12;
            if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
            else n = n + $urandom_range(0, 3);
            queue_file(FK_NONE, rand_bits(), sz, n, 1'b1);
         end else if (kind < 90) begin
            queue_file($urandom_range(FK_HDR_ID, FK_DATA_SIZE), rand_bits(),
                       12 + $urandom_range(0, 30), $urandom_range(0, 10), 1'b1);
         end else if (kind < 95) begin
            queue_file(FK_NONE, rand_bits(), rand64() >> $urandom_range(0, 63),
                       $urandom_range(0, 20), 1'b1);
         end else begin
            repeat ($urandom_range(1, 40)) begin
               r.data_byte = 8'($urandom);
               r.start_of_file = ($urandom_range(0, 15) == 0);
               pending_bytes.push_back(r);
            end
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (pending_bytes.size() != 0 || push) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("dsf_stream_parse_deinterleave_tb passed");
      end else begin
         $display("dsf_stream_parse_deinterleave_tb failed");
      end
      $finish;
   end

   // sender: bursts of beats separated by random gaps
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) parse_byte(req_data);
         if (push && full) begin
            // hold the offered beat
         end else if (gap_left > 0) begin
            gap_left--;
            push <= 1'b0;
         end else if (pending_bytes.size() != 0) begin
            req_data <= pending_bytes.pop_front();
            push <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                        : $urandom_range(1, 30);
               gap_left = $urandom_range(0, 7);
            end
         end else begin
            push <= 1'b0;
         end
      end
   end

   // receiver: check each beat, stall in windows of changing density
   int stall_mode = 0;
   int window_left = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;

   always @(posedge clock) begin
      rsp_type e;
      logic    next_pop;
      if (!reset && pop && !empty) begin
         result_count++;
         if (expected_results.size() == 0) begin
            $error("unexpected result beat: %p", rsp_data);
            fail_count++;
         end else begin
            e = expected_results.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.left_byte !== e.left_byte) begin
               $error("left_byte: expected %h, got %h", e.left_byte, rsp_data.left_byte);
               fail_count++;
            end
            if (rsp_data.right_byte !== e.right_byte) begin
               $error("right_byte: expected %h, got %h", e.right_byte, rsp_data.right_byte);
               fail_count++;
            end
            if (rsp_data.data_bytes !== e.data_bytes) begin
               $error("data_bytes: expected %0d, got %0d", e.data_bytes, rsp_data.data_bytes);
               fail_count++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last: expected %b, got %b", e.last, rsp_data.last);
               fail_count++;
            end
         end
      end
      // one long hold-off to back the block up into its input
      if (!hold_done && result_count >= 40) begin
         hold_done = 1'b1;
         hold_left = 300;
      end
      if (window_left == 0) begin
         window_left = $urandom_range(10, 80);
         stall_mode = $urandom_range(0, 2);
      end
      window_left--;
      if (hold_left > 0) begin
         hold_left--;
         next_pop = 1'b0;
      end else begin
         case (stall_mode)
            0:       next_pop = 1'b1;
            1:       next_pop = $urandom_range(0, 1);
            default: next_pop = ($urandom_range(0, 4) == 0);
         endcase
      end
      pop <= next_pop;
   end

   // watchdog: end the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("dsf_stream_parse_deinterleave_tb failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

// File: sim.f
hw/rtl/dsf_pkg.sv
hw/rtl/dsf_ram.sv
hw/rtl/dsf_front.sv
hw/rtl/dsf_back.sv
hw/rtl/dsf_stream_parse_deinterleave.sv
sim/dsf_stream_parse_deinterleave_tb.sv
